// File: hdl/cps_pkg.sv
// Package for the convex support point search core.
// Holds the shared widths, the vector type, action and register codes and
// the scan-length helper. No dependencies.
package cps_pkg;

  // Table depth and coordinate width.
  localparam int MAX_ENTRIES = 256;
  localparam int COORD_BITS  = 18;

  // Derived widths.
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int ADDR_W      = IDX_W + 1;
  localparam int PROD_W      = 2 * COORD_BITS;
  localparam int DOT_W       = PROD_W + 2;
  localparam int CNT_W       = 9;
  localparam int ENTRY_IDX_W = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DOT_W-1:0]      dot_t;

  // One stored 3-vector.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  // Input word actions.
  typedef enum logic [1:0] {
    ACT_WR_VERTEX = 2'd0,
    ACT_WR_FACE   = 2'd1,
    ACT_Q_VERTEX  = 2'd2,
    ACT_Q_FACE    = 2'd3
  } act_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_VERTEX_COUNT = 1'b0,
    REG_FACE_COUNT   = 1'b1
  } reg_e;

  // Component selected for the shared multiplier.
  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2
  } comp_e;

  // Control word from the sequencer to the dot-product unit.
  typedef struct packed {
    logic  mul_en;
    comp_e comp;
    logic  acc_clr;
    logic  acc_en;
  } mac_ctl_t;

  // Last index to scan: a count of zero scans entry 0, a count above the
  // table depth scans the whole table.
  function automatic logic [IDX_W-1:0] last_index(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] cnt_m1;
    cnt_m1 = cnt - CNT_W'(1);
    if (cnt == '0) begin
      return '0;
    end else if (cnt > CNT_W'(MAX_ENTRIES)) begin
      return IDX_W'(MAX_ENTRIES - 1);
    end else begin
      return cnt_m1[IDX_W-1:0];
    end
  endfunction

endpackage

// File: hdl/cps_store.sv
// Vertex and face-normal tables in one memory, one write and one read port.
// The table select is the top address bit. Depends on cps_pkg.
module cps_store (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [cps_pkg::ADDR_W-1:0] waddr_i,
  input  cps_pkg::vec_t          wdata_i,
  input  logic                   re_i,
  input  logic [cps_pkg::ADDR_W-1:0] raddr_i,
  output cps_pkg::vec_t          rdata_o
);

  cps_pkg::vec_t mem_q [2*cps_pkg::MAX_ENTRIES];
  cps_pkg::vec_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/cps_dot_unit.sv
// Shared multiply-accumulate unit: one signed multiply per cycle, three
// multiplies per dot product. Depends on cps_pkg.
module cps_dot_unit (
  input  logic              clk_i,
  input  cps_pkg::mac_ctl_t ctl_i,
  input  cps_pkg::vec_t     entry_i,
  input  cps_pkg::vec_t     dir_i,
  output cps_pkg::dot_t     dot_o
);

  cps_pkg::coord_t op_a;
  cps_pkg::coord_t op_b;
  cps_pkg::prod_t  prod_q;
  cps_pkg::dot_t   acc_q;

  // Operand select for the shared multiplier.
  always_comb begin
    unique case (ctl_i.comp)
      cps_pkg::COMP_X: begin
        op_a = entry_i.x;
        op_b = dir_i.x;
      end
      cps_pkg::COMP_Y: begin
        op_a = entry_i.y;
        op_b = dir_i.y;
      end
      cps_pkg::COMP_Z: begin
        op_a = entry_i.z;
        op_b = dir_i.z;
      end
      default: begin
        op_a = entry_i.x;
        op_b = dir_i.x;
      end
    endcase
  end

  // Product register, then accumulator.
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= op_a * op_b;
    end
    if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + cps_pkg::DOT_W'(prod_q);
    end
  end

  // The last product is folded in on the way out.
  assign dot_o = acc_q + cps_pkg::DOT_W'(prod_q);

endmodule

// File: hdl/convex_support_point_search_core.sv
// Top level of the convex support point search core: sequencer, count
// registers and output register. Depends on cps_pkg, cps_store, cps_dot_unit.
//
// Usage:
// The input channel (in_valid_i / in_stall_o) carries one word per item:
// an action, an entry index and a 3-vector. Write actions store the vector
// in the vertex or face-normal table and return no word; a write does not
// stall the input. Query actions scan entries 0 .. count-1 of one table and
// return one output word (out_valid_o / out_stall_i) with the table kind,
// the index of the largest dot product (lowest index on ties) and that value.
// For each entry the sequencer does one memory read, three passes through
// the single shared multiplier and one compare. in_stall_o is high for
// the whole scan. The output register lets a new word be accepted while a
// result waits; a finished scan holds in its last state while the
// receiver stalls and the output register is still full.
// Reset clears the sequencer and output valid and sets the counts to 8
// vertices and 6 faces; the tables are not cleared and must be written
// before they are queried. Counts are written through cfg_we_i; the user
// must write them only while idle, which the block does not enforce.
module convex_support_point_search_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [cps_pkg::CNT_W-1:0]          cfg_data_i,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [cps_pkg::ENTRY_IDX_W-1:0]    entry_index_i,
  input  logic signed [cps_pkg::COORD_BITS-1:0] vec_x_i,
  input  logic signed [cps_pkg::COORD_BITS-1:0] vec_y_i,
  input  logic signed [cps_pkg::COORD_BITS-1:0] vec_z_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               result_kind_o,
  output logic [cps_pkg::ENTRY_IDX_W-1:0]    best_index_o,
  output logic signed [cps_pkg::DOT_W-1:0]   best_dot_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_MX   = 7'b0000100,
    S_MY   = 7'b0001000,
    S_MZ   = 7'b0010000,
    S_CMP  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e                        state_q, state_d;
  logic [cps_pkg::CNT_W-1:0]     vcount_q, fcount_q;
  logic                          tbl_q;
  cps_pkg::vec_t                 dir_q;
  logic [cps_pkg::IDX_W-1:0]     idx_q, last_q;
  logic [cps_pkg::IDX_W-1:0]     best_idx_q;
  cps_pkg::dot_t                 best_dot_q;
  logic                          out_valid_q;
  logic                          kind_q;
  logic [cps_pkg::IDX_W-1:0]     out_idx_q;
  cps_pkg::dot_t                 out_dot_q;

  logic                          in_acc;
  logic                          is_query;
  logic                          wr_en;
  cps_pkg::vec_t                 in_vec;
  cps_pkg::vec_t                 entry;
  cps_pkg::dot_t                 dot;
  cps_pkg::mac_ctl_t             mac_ctl;
  logic                          out_load;

  assign in_vec   = '{x: vec_x_i, y: vec_y_i, z: vec_z_i};
  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_query = (cps_pkg::act_e'(action_i) == cps_pkg::ACT_Q_VERTEX) ||
                    (cps_pkg::act_e'(action_i) == cps_pkg::ACT_Q_FACE);
  // Writes beyond the table depth are dropped.
  assign wr_en    = in_acc && !is_query &&
                    (cps_pkg::CNT_W'(entry_index_i) < cps_pkg::CNT_W'(cps_pkg::MAX_ENTRIES));
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Table memory; bit 0 of the action picks the table for writes and queries.
  cps_store u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i ({action_i[0], entry_index_i[cps_pkg::IDX_W-1:0]}),
    .wdata_i (in_vec),
    .re_i    (state_q == S_READ),
    .raddr_i ({tbl_q, idx_q}),
    .rdata_o (entry)
  );

  cps_dot_unit u_dot (
    .clk_i   (clk_i),
    .ctl_i   (mac_ctl),
    .entry_i (entry),
    .dir_i   (dir_q),
    .dot_o   (dot)
  );

  // Multiplier control per sequencer state.
  always_comb begin
    mac_ctl = '{mul_en: 1'b0, comp: cps_pkg::COMP_X, acc_clr: 1'b0, acc_en: 1'b0};
    unique case (state_q)
      S_MX: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.comp    = cps_pkg::COMP_X;
        mac_ctl.acc_clr = 1'b1;
      end
      S_MY: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.comp   = cps_pkg::COMP_Y;
        mac_ctl.acc_en = 1'b1;
      end
      S_MZ: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.comp   = cps_pkg::COMP_Z;
        mac_ctl.acc_en = 1'b1;
      end
      default: begin
        mac_ctl.mul_en = 1'b0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && is_query) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_MX;
      S_MX:   state_d = S_MY;
      S_MY:   state_d = S_MZ;
      S_MZ:   state_d = S_CMP;
      S_CMP: begin
        state_d = (idx_q == last_q) ? S_OUT : S_READ;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= cps_pkg::CNT_W'(8);
      fcount_q    <= cps_pkg::CNT_W'(6);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cps_pkg::reg_e'(cfg_idx_i))
          cps_pkg::REG_VERTEX_COUNT: vcount_q <= cfg_data_i;
          cps_pkg::REG_FACE_COUNT:   fcount_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Query context and running best.
  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      dir_q  <= in_vec;
      tbl_q  <= action_i[0];
      idx_q  <= '0;
      last_q <= cps_pkg::last_index(action_i[0] ? fcount_q : vcount_q);
    end
    if (state_q == S_CMP) begin
      // Strictly greater keeps the lowest index on ties.
      if (idx_q == '0 || dot > best_dot_q) begin
        best_dot_q <= dot;
        best_idx_q <= idx_q;
      end
      if (idx_q != last_q) begin
        idx_q <= idx_q + cps_pkg::IDX_W'(1);
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q    <= tbl_q;
      out_idx_q <= best_idx_q;
      out_dot_q <= best_dot_q;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign best_index_o  = cps_pkg::ENTRY_IDX_W'(out_idx_q);
  assign best_dot_o    = out_dot_q;

  // The winning index never lies beyond the scanned range.
  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (best_idx_q <= last_q))
    else $error("best index beyond scan range");

  // An accepted query starts a scan and blocks the input next cycle.
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_query) |=> in_stall_o)
    else $error("query did not start a scan");

  // A write returns to accepting words at once.
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_query) |=> !in_stall_o)
    else $error("write did not complete in one cycle");

  // A new result word only appears from the final state of a scan.
  a_out_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result word without a finished scan");

endmodule

// File: tb/convex_support_point_search_core_tb.sv
// Self-checking testbench for convex_support_point_search_core.
// A directed table followed by random phases, checked against a support-search predictor.
// Depends on cps_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module convex_support_point_search_core_tb;

  localparam cps_pkg::coord_t C_MAX = cps_pkg::coord_t'(18'h1FFFF);
  localparam cps_pkg::coord_t C_MIN = cps_pkg::coord_t'(18'h20000);
  localparam cps_pkg::coord_t C_ONE = cps_pkg::coord_t'(1);
  localparam cps_pkg::coord_t C_NEG = cps_pkg::coord_t'(18'h3FFFF);

  // Expected answer of one query.
  typedef struct packed {
    logic                            kind;
    logic [cps_pkg::ENTRY_IDX_W-1:0] idx;
    cps_pkg::dot_t                   dot;
  } answer_t;

  // One row of the directed table: a count update or an input word.
  typedef struct {
    bit                              is_cfg;
    logic [cps_pkg::CNT_W-1:0]       vcnt;
    logic [cps_pkg::CNT_W-1:0]       fcnt;
    cps_pkg::act_e                   act;
    logic [cps_pkg::ENTRY_IDX_W-1:0] idx;
    cps_pkg::vec_t                   vec;
    bit                              typed;
    answer_t                         want;
  } stim_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic                            cfg_idx_i = cps_pkg::REG_VERTEX_COUNT;
  logic [cps_pkg::CNT_W-1:0]       cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [1:0]                      action_i = cps_pkg::ACT_WR_VERTEX;
  logic [cps_pkg::ENTRY_IDX_W-1:0] entry_index_i = '0;
  cps_pkg::coord_t                 vec_x_i = '0;
  cps_pkg::coord_t                 vec_y_i = '0;
  cps_pkg::coord_t                 vec_z_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic                            result_kind_o;
  logic [cps_pkg::ENTRY_IDX_W-1:0] best_index_o;
  cps_pkg::dot_t                   best_dot_o;

  // Predictor state: both tables and both counts.
  cps_pkg::vec_t             vtx_tab [cps_pkg::MAX_ENTRIES];
  cps_pkg::vec_t             nrm_tab [cps_pkg::MAX_ENTRIES];
  logic [cps_pkg::CNT_W-1:0] vtx_cnt = 9'd8;
  logic [cps_pkg::CNT_W-1:0] nrm_cnt = 9'd6;

  answer_t     answers[$];
  stim_row_t   plan[$];
  int unsigned mismatches = 0;
  bit          steady = 1'b0;

  convex_support_point_search_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .entry_index_i (entry_index_i),
    .vec_x_i       (vec_x_i),
    .vec_y_i       (vec_y_i),
    .vec_z_i       (vec_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .best_index_o  (best_index_o),
    .best_dot_o    (best_dot_o)
  );

  always #6 clk_i = ~clk_i;

  // Run limit, far above the slowest legal run.
  initial begin
    #240_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Apply one accepted word to the predictor; returns 1 when it yields an answer.
  function automatic bit model_word(cps_pkg::act_e a, logic [cps_pkg::ENTRY_IDX_W-1:0] idx,
                                    cps_pkg::vec_t v, output answer_t ans);
    cps_pkg::vec_t ent;
    int            n;
    int            win;
    longint        d;
    longint        best;
    ans = '0;
    best = 0;
    win = 0;
    case (a)
      cps_pkg::ACT_WR_VERTEX: begin
        vtx_tab[idx] = v;
        return 1'b0;
      end
      cps_pkg::ACT_WR_FACE: begin
        nrm_tab[idx] = v;
        return 1'b0;
      end
      default: begin
        n = (a == cps_pkg::ACT_Q_VERTEX) ? int'(vtx_cnt) : int'(nrm_cnt);
        // A zero count still scans entry 0; large counts stop at the table end.
        if (n == 0) begin
          n = 1;
        end else if (n > cps_pkg::MAX_ENTRIES) begin
          n = cps_pkg::MAX_ENTRIES;
        end
        for (int i = 0; i < n; i++) begin
          ent = (a == cps_pkg::ACT_Q_VERTEX) ? vtx_tab[i] : nrm_tab[i];
          d = longint'($signed(ent.x)) * longint'($signed(v.x))
            + longint'($signed(ent.y)) * longint'($signed(v.y))
            + longint'($signed(ent.z)) * longint'($signed(v.z));
          // Strictly greater, so the lowest index keeps a tie.
          if (i == 0 || d > best) begin
            best = d;
            win = i;
          end
        end
        ans.kind = (a == cps_pkg::ACT_Q_FACE);
        ans.idx = win[cps_pkg::ENTRY_IDX_W-1:0];
        ans.dot = cps_pkg::dot_t'(best);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic cps_pkg::coord_t pick_coord(int unsigned style);
    case (style)
      0: return cps_pkg::coord_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          3: return C_NEG;
          default: return C_ONE;
        endcase
      end
      default: return cps_pkg::coord_t'($urandom_range(0, 4) - 2);
    endcase
  endfunction

  // Mostly full-range vectors; extremes and tiny values make ties likely.
  function automatic cps_pkg::vec_t rand_vec();
    int unsigned   r;
    int unsigned   style;
    cps_pkg::vec_t v;
    r = $urandom_range(0, 99);
    style = (r < 60) ? 0 : ((r < 80) ? 1 : 2);
    v.x = pick_coord(style);
    v.y = pick_coord(style);
    v.z = pick_coord(style);
    return v;
  endfunction

  function automatic void plan_word(cps_pkg::act_e a, logic [cps_pkg::ENTRY_IDX_W-1:0] idx,
                                    cps_pkg::vec_t v);
    stim_row_t row;
    row = '{act: cps_pkg::ACT_WR_VERTEX, default: '0};
    row.act = a;
    row.idx = idx;
    row.vec = v;
    plan.push_back(row);
  endfunction

  function automatic void plan_check(cps_pkg::act_e a, cps_pkg::vec_t v,
                                     logic [cps_pkg::ENTRY_IDX_W-1:0] bidx,
                                     cps_pkg::dot_t bdot);
    stim_row_t row;
    row = '{act: cps_pkg::ACT_WR_VERTEX, default: '0};
    row.act = a;
    row.idx = '1;
    row.vec = v;
    row.typed = 1'b1;
    row.want.kind = (a == cps_pkg::ACT_Q_FACE);
    row.want.idx = bidx;
    row.want.dot = bdot;
    plan.push_back(row);
  endfunction

  function automatic void plan_counts(logic [cps_pkg::CNT_W-1:0] v,
                                      logic [cps_pkg::CNT_W-1:0] f);
    stim_row_t row;
    row = '{act: cps_pkg::ACT_WR_VERTEX, default: '0};
    row.is_cfg = 1'b1;
    row.vcnt = v;
    row.fcnt = f;
    plan.push_back(row);
  endfunction

  // Present one word, idling at random first, and hold it until accepted.
  task automatic send_word(cps_pkg::act_e a, logic [cps_pkg::ENTRY_IDX_W-1:0] idx,
                           cps_pkg::vec_t v);
    while (!steady && $urandom_range(0, 99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= a;
    entry_index_i <= idx;
    vec_x_i <= v.x;
    vec_y_i <= v.y;
    vec_z_i <= v.z;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic push_word(cps_pkg::act_e a, logic [cps_pkg::ENTRY_IDX_W-1:0] idx,
                           cps_pkg::vec_t v);
    answer_t ans;
    send_word(a, idx, v);
    if (model_word(a, idx, v, ans)) begin
      answers.push_back(ans);
    end
  endtask

  task automatic random_query();
    if ($urandom_range(0, 1) == 1) begin
      push_word(cps_pkg::ACT_Q_FACE, cps_pkg::ENTRY_IDX_W'($urandom), rand_vec());
    end else begin
      push_word(cps_pkg::ACT_Q_VERTEX, cps_pkg::ENTRY_IDX_W'($urandom), rand_vec());
    end
  endtask

  // Wait until every answer is in and the last write has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Rewrite both counts, one after the other, while the core is idle.
  task automatic set_counts(logic [cps_pkg::CNT_W-1:0] v, logic [cps_pkg::CNT_W-1:0] f);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= cps_pkg::REG_VERTEX_COUNT;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_idx_i <= cps_pkg::REG_FACE_COUNT;
    cfg_data_i <= f;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vtx_cnt = v;
    nrm_cnt = f;
  endtask

  function automatic logic [cps_pkg::CNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return cps_pkg::CNT_W'($urandom_range(1, 8));
    if (r < 70) return cps_pkg::CNT_W'($urandom_range(9, 64));
    if (r < 78) return '0;
    if (r < 84) return cps_pkg::CNT_W'(1);
    if (r < 90) return cps_pkg::CNT_W'(cps_pkg::MAX_ENTRIES);
    if (r < 95) return cps_pkg::CNT_W'($urandom_range(cps_pkg::MAX_ENTRIES + 1, 511));
    return cps_pkg::CNT_W'(cps_pkg::MAX_ENTRIES - 1);
  endfunction

  // Receiver: random stalls, none during the steady stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 23);
  end

  // Compare every accepted result word with the oldest expected answer.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answers.size() == 0) begin
        $error("result word with no query waiting: kind %0d index %0d dot %0d",
               result_kind_o, best_index_o, best_dot_o);
        mismatches++;
      end else begin
        want = answers.pop_front();
        if (result_kind_o !== want.kind) begin
          $error("result_kind: expected %0d, actual %0d", want.kind, result_kind_o);
          mismatches++;
        end
        if (best_index_o !== want.idx) begin
          $error("best_index: expected %0d, actual %0d", want.idx, best_index_o);
          mismatches++;
        end
        if (best_dot_o !== want.dot) begin
          $error("best_dot: expected %0d, actual %0d", want.dot, best_dot_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    answer_t ans;
    int unsigned r;

    // Reset counts (8 vertices, 6 faces): two equal largest vertices, an opposite one at the last index.
    for (int i = 0; i < 8; i++) begin
      if (i == 3 || i == 6) begin
        plan_word(cps_pkg::ACT_WR_VERTEX, cps_pkg::ENTRY_IDX_W'(i),
                  cps_pkg::vec_t'({C_MAX, C_MAX, C_MAX}));
      end else if (i == 7) begin
        plan_word(cps_pkg::ACT_WR_VERTEX, cps_pkg::ENTRY_IDX_W'(i),
                  cps_pkg::vec_t'({C_MIN, C_MIN, C_MIN}));
      end else begin
        plan_word(cps_pkg::ACT_WR_VERTEX, cps_pkg::ENTRY_IDX_W'(i), cps_pkg::vec_t'('0));
      end
    end
    for (int i = 0; i < 6; i++) begin
      if (i == 4) begin
        plan_word(cps_pkg::ACT_WR_FACE, cps_pkg::ENTRY_IDX_W'(i),
                  cps_pkg::vec_t'({C_MIN, C_MIN, C_MIN}));
      end else begin
        plan_word(cps_pkg::ACT_WR_FACE, cps_pkg::ENTRY_IDX_W'(i), cps_pkg::vec_t'('0));
      end
    end
    plan_check(cps_pkg::ACT_Q_VERTEX, cps_pkg::vec_t'({18'sd0, 18'sd0, C_ONE}), 8'd3,
               cps_pkg::dot_t'(38'sd131071));
    plan_check(cps_pkg::ACT_Q_VERTEX, cps_pkg::vec_t'({18'sd0, 18'sd0, C_NEG}), 8'd7,
               cps_pkg::dot_t'(38'sd131072));
    plan_check(cps_pkg::ACT_Q_FACE, cps_pkg::vec_t'({C_MIN, C_MIN, C_MIN}), 8'd4,
               cps_pkg::dot_t'(38'sd51539607552));
    plan_check(cps_pkg::ACT_Q_FACE, cps_pkg::vec_t'({C_ONE, C_ONE, C_ONE}), 8'd0,
               cps_pkg::dot_t'(38'sd0));
    // Zero counts scan only entry 0; extreme products.
    plan_counts(9'd0, 9'd0);
    plan_word(cps_pkg::ACT_WR_VERTEX, 8'd0, cps_pkg::vec_t'({C_MAX, C_MAX, C_MAX}));
    plan_check(cps_pkg::ACT_Q_VERTEX, cps_pkg::vec_t'({C_MAX, C_MAX, C_MAX}), 8'd0,
               cps_pkg::dot_t'(38'sd51538821123));
    plan_check(cps_pkg::ACT_Q_VERTEX, cps_pkg::vec_t'({C_MIN, C_MIN, C_MIN}), 8'd0,
               cps_pkg::dot_t'(-64'sd51539214336));
    plan_check(cps_pkg::ACT_Q_FACE, cps_pkg::vec_t'({C_MAX, C_MIN, C_MAX}), 8'd0,
               cps_pkg::dot_t'(38'sd0));
    plan_word(cps_pkg::ACT_WR_FACE, 8'd0, cps_pkg::vec_t'({C_MIN, C_MAX, C_MIN}));
    plan_word(cps_pkg::ACT_Q_FACE, 8'd255, cps_pkg::vec_t'({C_MIN, C_MAX, C_MIN}));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        set_counts(plan[k].vcnt, plan[k].fcnt);
      end else begin
        send_word(plan[k].act, plan[k].idx, plan[k].vec);
        if (model_word(plan[k].act, plan[k].idx, plan[k].vec, ans)) begin
          answers.push_back(plan[k].typed ? plan[k].want : ans);
        end
      end
    end

    // Fill both tables so any count is legal; queries here only see entry 0.
    for (int i = 0; i < cps_pkg::MAX_ENTRIES; i++) begin
      push_word(cps_pkg::ACT_WR_VERTEX, cps_pkg::ENTRY_IDX_W'(i), rand_vec());
      push_word(cps_pkg::ACT_WR_FACE, cps_pkg::ENTRY_IDX_W'(i), rand_vec());
      if ($urandom_range(0, 99) < 15) begin
        random_query();
      end
    end

    // Random phases, each under its own pair of counts.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: set_counts(cps_pkg::CNT_W'(cps_pkg::MAX_ENTRIES), 9'd511);
        1: set_counts(9'd1, 9'd0);
        2: set_counts(9'd511, cps_pkg::CNT_W'(cps_pkg::MAX_ENTRIES));
        default: set_counts(pick_count(), pick_count());
      endcase
      steady = (ph == 5 || ph == 6);
      for (int k = 0; k < 40; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          random_query();
        end else if (r < 72) begin
          push_word(cps_pkg::ACT_WR_VERTEX, cps_pkg::ENTRY_IDX_W'($urandom), rand_vec());
        end else begin
          push_word(cps_pkg::ACT_WR_FACE, cps_pkg::ENTRY_IDX_W'($urandom), rand_vec());
        end
      end
    end
    steady = 1'b0;

    drain();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
